FILE: rtl/expression_tokenizer_top_defines.svh
// Assertion macros for the expression tokenizer.
// Included by the top level; no other dependencies.
`ifndef EXPRESSION_TOKENIZER_TOP_DEFINES_SVH
`define EXPRESSION_TOKENIZER_TOP_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define EXPTOK_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("exptok: implication check failed");
// Next-cycle implication, disabled during reset.
`define EXPTOK_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("exptok: next-cycle check failed");
`else
`define EXPTOK_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define EXPTOK_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/exptok_pkg.sv
// Shared types, constants and character-class functions of the expression tokenizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package exptok_pkg;

    // Field widths.
    localparam int POSITION_BITS = 16;
    localparam int LENGTH_BITS   = 8;
    localparam int KIND_BITS     = 4;
    localparam int BYTE_BITS     = 8;

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0]   LEN_ONE = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0]   LEN_MAX = {LENGTH_BITS{1'b1}};

    // Result queue sizing.
    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_BITS:0] ACCEPT_LIMIT = (CNT_BITS + 1)'(QUEUE_DEPTH - 2);

    // Tokens pushed per step.
    localparam int PUSH_BITS = 2;
    localparam logic [PUSH_BITS-1:0] PUSH_NONE = 2'd0;
    localparam logic [PUSH_BITS-1:0] PUSH_ONE  = 2'd1;
    localparam logic [PUSH_BITS-1:0] PUSH_TWO  = 2'd2;

    // Input function codes.
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // Token kinds.
    localparam logic [KIND_BITS-1:0] KIND_NUM     = 4'd0;
    localparam logic [KIND_BITS-1:0] KIND_IDENT   = 4'd1;
    localparam logic [KIND_BITS-1:0] KIND_PLUS    = 4'd2;
    localparam logic [KIND_BITS-1:0] KIND_MINUS   = 4'd3;
    localparam logic [KIND_BITS-1:0] KIND_STAR    = 4'd4;
    localparam logic [KIND_BITS-1:0] KIND_SLASH   = 4'd5;
    localparam logic [KIND_BITS-1:0] KIND_COMMA   = 4'd6;
    localparam logic [KIND_BITS-1:0] KIND_EQUAL   = 4'd7;
    localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 4'd8;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 4'd9;
    localparam logic [KIND_BITS-1:0] KIND_INVALID = 4'd10;
    localparam logic [KIND_BITS-1:0] KIND_END     = 4'd11;
    localparam logic [KIND_BITS-1:0] KIND_ERROR   = 4'd12;

    // Character codes.
    localparam logic [BYTE_BITS-1:0] CH_PLUS   = 8'h2B;
    localparam logic [BYTE_BITS-1:0] CH_MINUS  = 8'h2D;
    localparam logic [BYTE_BITS-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_BITS-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_BITS-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_BITS-1:0] CH_EQUAL  = 8'h3D;
    localparam logic [BYTE_BITS-1:0] CH_LPAREN = 8'h28;
    localparam logic [BYTE_BITS-1:0] CH_RPAREN = 8'h29;
    localparam logic [BYTE_BITS-1:0] CH_DOT    = 8'h2E;
    localparam logic [BYTE_BITS-1:0] CH_UNDER  = 8'h5F;
    localparam logic [BYTE_BITS-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_BITS-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_BITS-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_BITS-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_BITS-1:0] CH_NINE   = 8'h39;
    localparam logic [BYTE_BITS-1:0] CH_LA     = 8'h61;
    localparam logic [BYTE_BITS-1:0] CH_LZ     = 8'h7A;
    localparam logic [BYTE_BITS-1:0] CH_UA     = 8'h41;
    localparam logic [BYTE_BITS-1:0] CH_UZ     = 8'h5A;

    // One result item.
    typedef struct packed {
        logic [KIND_BITS-1:0]     token_kind;
        logic [POSITION_BITS-1:0] start_line;
        logic [POSITION_BITS-1:0] start_column;
        logic [LENGTH_BITS-1:0]   token_length;
        logic [BYTE_BITS-1:0]     first_byte;
        logic                     last;
    } token_t;

    // Tokens produced by one step, handed from the lexer to the queue.
    typedef struct packed {
        logic [PUSH_BITS-1:0] count;
        token_t               tok0;
        token_t               tok1;
    } push_t;

    // Queue fill level, seen by the lexer for flow control.
    typedef struct packed {
        logic [CNT_BITS-1:0] count;
    } queue_status_t;

    function automatic logic is_digit(input logic [BYTE_BITS-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [BYTE_BITS-1:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
    endfunction

    function automatic logic is_word(input logic [BYTE_BITS-1:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_space(input logic [BYTE_BITS-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    // Operator kind, or KIND_NUM when the byte is no operator.
    function automatic logic [KIND_BITS-1:0] op_kind(input logic [BYTE_BITS-1:0] c);
        logic [KIND_BITS-1:0] k;
        unique case (c)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_STAR;
            CH_SLASH:  k = KIND_SLASH;
            CH_COMMA:  k = KIND_COMMA;
            CH_EQUAL:  k = KIND_EQUAL;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            default:   k = KIND_NUM;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/exptok_ifs.sv
// Valid/ready channel interfaces for the source-byte input and the token output.
// Depends on exptok_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface exptok_in_if;
    logic                            valid;
    logic                            ready;
    logic                            func;
    logic [exptok_pkg::BYTE_BITS-1:0] char_code;

    modport source (output valid, output func, output char_code, input ready);
    modport sink (input valid, input func, input char_code, output ready);
endinterface

interface exptok_out_if;
    logic                                valid;
    logic                                ready;
    logic [exptok_pkg::KIND_BITS-1:0]     token_kind;
    logic [exptok_pkg::POSITION_BITS-1:0] start_line;
    logic [exptok_pkg::POSITION_BITS-1:0] start_column;
    logic [exptok_pkg::LENGTH_BITS-1:0]   token_length;
    logic [exptok_pkg::BYTE_BITS-1:0]     first_byte;
    logic                                last;

    modport source (output valid, output token_kind, output start_line,
                    output start_column, output token_length, output first_byte,
                    output last, input ready);
    modport sink (input valid, input token_kind, input start_line,
                  input start_column, input token_length, input first_byte,
                  input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/exptok_lexer.sv
// Input register, scan state and per-byte tokenizing logic.
// Depends on exptok_pkg and exptok_ifs.
`timescale 1ns / 1ps
`default_nettype none

module exptok_lexer
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    exptok_in_if.sink                       in_ch,
    input  wire exptok_pkg::queue_status_t  q_status,
    output exptok_pkg::push_t               push
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_DOT,
        MODE_FRAC,
        MODE_IDENT,
        MODE_HALT
    } mode_t;

    // Input register.
    logic                             stage_valid_reg;
    logic                             func_reg;
    logic [exptok_pkg::BYTE_BITS-1:0] char_reg;

    // Scan state.
    mode_t                                mode_reg, mode_next;
    logic [exptok_pkg::POSITION_BITS-1:0] cur_line_reg, cur_line_next;
    logic [exptok_pkg::POSITION_BITS-1:0] cur_col_reg, cur_col_next;
    logic [exptok_pkg::POSITION_BITS-1:0] pend_line_reg, pend_line_next;
    logic [exptok_pkg::POSITION_BITS-1:0] pend_col_reg, pend_col_next;
    logic [exptok_pkg::LENGTH_BITS-1:0]   pend_len_reg, pend_len_next;
    logic [exptok_pkg::BYTE_BITS-1:0]     pend_first_reg, pend_first_next;

    // Step decode.
    logic                              flush_en;
    logic [exptok_pkg::KIND_BITS-1:0]  flush_kind;
    logic                              idle_en;
    logic                              grow_en;
    logic                              sec_en;
    exptok_pkg::token_t                sec_tok;
    exptok_pkg::token_t                flush_tok;
    logic [exptok_pkg::POSITION_BITS-1:0] adv_line;
    logic [exptok_pkg::POSITION_BITS-1:0] adv_col;
    logic [exptok_pkg::CNT_BITS:0]     room_used;

    // Accept only when the queue has room for this item and the one in the register.
    assign room_used = {1'b0, q_status.count}
                     + (stage_valid_reg ? (exptok_pkg::CNT_BITS + 1)'(2)
                                        : (exptok_pkg::CNT_BITS + 1)'(0));
    assign in_ch.ready = (room_used <= exptok_pkg::ACCEPT_LIMIT);

    // Position after the current byte, saturating.
    always_comb
    begin
        adv_line = cur_line_reg;
        adv_col  = cur_col_reg;
        if (char_reg == exptok_pkg::CH_LF)
        begin
            if (cur_line_reg != exptok_pkg::POS_MAX)
            begin
                adv_line = cur_line_reg + exptok_pkg::POS_ONE;
            end
            adv_col = exptok_pkg::POS_ONE;
        end
        else if (cur_col_reg != exptok_pkg::POS_MAX)
        begin
            adv_col = cur_col_reg + exptok_pkg::POS_ONE;
        end
    end

    // Mode transitions and the tokens one step emits.
    always_comb
    begin
        mode_next       = mode_reg;
        cur_line_next   = cur_line_reg;
        cur_col_next    = cur_col_reg;
        pend_line_next  = pend_line_reg;
        pend_col_next   = pend_col_reg;
        pend_len_next   = pend_len_reg;
        pend_first_next = pend_first_reg;
        flush_en        = 1'b0;
        flush_kind      = exptok_pkg::KIND_NUM;
        idle_en         = 1'b0;
        grow_en         = 1'b0;
        sec_en          = 1'b0;
        sec_tok         = '0;

        if (stage_valid_reg)
        begin
            if (func_reg == exptok_pkg::FUNC_END)
            begin
                unique case (mode_reg)
                    MODE_INT, MODE_FRAC:
                    begin
                        flush_en   = 1'b1;
                        flush_kind = exptok_pkg::KIND_NUM;
                    end
                    MODE_IDENT:
                    begin
                        flush_en   = 1'b1;
                        flush_kind = exptok_pkg::KIND_IDENT;
                    end
                    MODE_DOT:
                    begin
                        flush_en   = 1'b1;
                        flush_kind = exptok_pkg::KIND_ERROR;
                    end
                    default:
                    begin
                    end
                endcase
                sec_en               = 1'b1;
                sec_tok.token_kind   = exptok_pkg::KIND_END;
                sec_tok.start_line   = cur_line_reg;
                sec_tok.start_column = cur_col_reg;
                mode_next            = MODE_IDLE;
                cur_line_next        = exptok_pkg::POS_ONE;
                cur_col_next         = exptok_pkg::POS_ONE;
                pend_line_next       = exptok_pkg::POS_ONE;
                pend_col_next        = exptok_pkg::POS_ONE;
                pend_len_next        = '0;
                pend_first_next      = '0;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_HALT:
                    begin
                    end
                    MODE_INT:
                    begin
                        if (exptok_pkg::is_digit(char_reg))
                        begin
                            grow_en = 1'b1;
                        end
                        else if (char_reg == exptok_pkg::CH_DOT)
                        begin
                            grow_en   = 1'b1;
                            mode_next = MODE_DOT;
                        end
                        else
                        begin
                            flush_en   = 1'b1;
                            flush_kind = exptok_pkg::KIND_NUM;
                            idle_en    = 1'b1;
                        end
                    end
                    MODE_DOT:
                    begin
                        if (exptok_pkg::is_digit(char_reg))
                        begin
                            grow_en   = 1'b1;
                            mode_next = MODE_FRAC;
                        end
                        else
                        begin
                            // The byte is dropped and the scanner halts.
                            flush_en   = 1'b1;
                            flush_kind = exptok_pkg::KIND_ERROR;
                            mode_next  = MODE_HALT;
                        end
                    end
                    MODE_FRAC:
                    begin
                        if (exptok_pkg::is_digit(char_reg))
                        begin
                            grow_en = 1'b1;
                        end
                        else
                        begin
                            flush_en   = 1'b1;
                            flush_kind = exptok_pkg::KIND_NUM;
                            idle_en    = 1'b1;
                        end
                    end
                    MODE_IDENT:
                    begin
                        if (exptok_pkg::is_word(char_reg))
                        begin
                            grow_en = 1'b1;
                        end
                        else
                        begin
                            flush_en   = 1'b1;
                            flush_kind = exptok_pkg::KIND_IDENT;
                            idle_en    = 1'b1;
                        end
                    end
                    default:
                    begin
                        idle_en = 1'b1;
                    end
                endcase

                // Extend the pending lexeme.
                if (grow_en)
                begin
                    if (pend_len_reg != exptok_pkg::LEN_MAX)
                    begin
                        pend_len_next = pend_len_reg + exptok_pkg::LEN_ONE;
                    end
                    cur_line_next = adv_line;
                    cur_col_next  = adv_col;
                end

                // Handle the byte as the start of a new token.
                if (idle_en)
                begin
                    mode_next     = MODE_IDLE;
                    cur_line_next = adv_line;
                    cur_col_next  = adv_col;
                    if (exptok_pkg::is_space(char_reg))
                    begin
                    end
                    else if (exptok_pkg::is_digit(char_reg) || exptok_pkg::is_alpha(char_reg)
                             || (char_reg == exptok_pkg::CH_UNDER))
                    begin
                        mode_next       = exptok_pkg::is_digit(char_reg) ? MODE_INT
                                                                         : MODE_IDENT;
                        pend_line_next  = cur_line_reg;
                        pend_col_next   = cur_col_reg;
                        pend_len_next   = exptok_pkg::LEN_ONE;
                        pend_first_next = char_reg;
                    end
                    else
                    begin
                        // Operator or invalid byte: a one-byte token.
                        sec_en               = 1'b1;
                        sec_tok.token_kind   = (exptok_pkg::op_kind(char_reg)
                                                != exptok_pkg::KIND_NUM)
                                               ? exptok_pkg::op_kind(char_reg)
                                               : exptok_pkg::KIND_INVALID;
                        sec_tok.start_line   = cur_line_reg;
                        sec_tok.start_column = cur_col_reg;
                        sec_tok.token_length = exptok_pkg::LEN_ONE;
                        sec_tok.first_byte   = char_reg;
                    end
                end
            end
        end
    end

    // Pending token as it is reported when closed.
    always_comb
    begin
        flush_tok              = '0;
        flush_tok.token_kind   = flush_kind;
        flush_tok.start_line   = pend_line_reg;
        flush_tok.start_column = pend_col_reg;
        flush_tok.token_length = pend_len_reg;
        flush_tok.first_byte   = pend_first_reg;
    end

    // Order the step's tokens and mark the final one.
    always_comb
    begin
        push.tok1      = sec_tok;
        push.tok1.last = 1'b1;
        if (flush_en)
        begin
            push.tok0      = flush_tok;
            push.tok0.last = !sec_en;
            push.count     = sec_en ? exptok_pkg::PUSH_TWO : exptok_pkg::PUSH_ONE;
        end
        else
        begin
            push.tok0      = sec_tok;
            push.tok0.last = 1'b1;
            push.count     = sec_en ? exptok_pkg::PUSH_ONE : exptok_pkg::PUSH_NONE;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            func_reg <= in_ch.func;
            char_reg <= in_ch.char_code;
        end
    end

    // Input valid flag and scan state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            mode_reg        <= MODE_IDLE;
            cur_line_reg    <= exptok_pkg::POS_ONE;
            cur_col_reg     <= exptok_pkg::POS_ONE;
            pend_line_reg   <= exptok_pkg::POS_ONE;
            pend_col_reg    <= exptok_pkg::POS_ONE;
            pend_len_reg    <= '0;
            pend_first_reg  <= '0;
        end
        else
        begin
            stage_valid_reg <= in_ch.valid && in_ch.ready;
            mode_reg        <= mode_next;
            cur_line_reg    <= cur_line_next;
            cur_col_reg     <= cur_col_next;
            pend_line_reg   <= pend_line_next;
            pend_col_reg    <= pend_col_next;
            pend_len_reg    <= pend_len_next;
            pend_first_reg  <= pend_first_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/exptok_queue.sv
// Result queue: takes up to two tokens per cycle and hands out one per transfer.
// Depends on exptok_pkg and exptok_ifs.
`timescale 1ns / 1ps
`default_nettype none

module exptok_queue
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire exptok_pkg::push_t      push,
    exptok_out_if.source                out_ch,
    output exptok_pkg::queue_status_t   q_status
);

    exptok_pkg::token_t                store_reg [exptok_pkg::QUEUE_DEPTH];
    logic [exptok_pkg::PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [exptok_pkg::PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [exptok_pkg::CNT_BITS-1:0]   count_reg, count_next;
    logic [exptok_pkg::PTR_BITS-1:0]   wr_ptr_plus1;
    logic                              pop;
    exptok_pkg::token_t                head;

    assign wr_ptr_plus1 = wr_ptr_reg + exptok_pkg::PTR_BITS'(1);
    assign pop          = out_ch.valid && out_ch.ready;
    assign head         = store_reg[rd_ptr_reg];

    // Output side.
    assign out_ch.valid        = (count_reg != '0);
    assign out_ch.token_kind   = head.token_kind;
    assign out_ch.start_line   = head.start_line;
    assign out_ch.start_column = head.start_column;
    assign out_ch.token_length = head.token_length;
    assign out_ch.first_byte   = head.first_byte;
    assign out_ch.last         = head.last;
    assign q_status.count      = count_reg;

    // Pointer and fill-level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + exptok_pkg::PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + (pop ? exptok_pkg::PTR_BITS'(1) : exptok_pkg::PTR_BITS'(0));
        count_next  = count_reg + exptok_pkg::CNT_BITS'(push.count)
                    - (pop ? exptok_pkg::CNT_BITS'(1) : exptok_pkg::CNT_BITS'(0));
    end

    // Token storage.
    always_ff @(posedge clk)
    begin
        if (push.count != exptok_pkg::PUSH_NONE)
        begin
            store_reg[wr_ptr_reg] <= push.tok0;
        end
        if (push.count == exptok_pkg::PUSH_TWO)
        begin
            store_reg[wr_ptr_plus1] <= push.tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/expression_tokenizer_top.sv
// Expression tokenizer: an accepted byte passes the lexer's input register and the result queue
// before its tokens reach the output. Throughput one byte per cycle while each byte yields at
// most one token and the output stays ready; a byte that closes a pending token and emits another
// costs two output transfers, drained one per cycle while the output is ready, from an 8-entry result queue.
// Reset (asynchronous, active low) empties the queue and returns to line 1, column 1.
// Top level; depends on exptok_pkg, exptok_ifs, exptok_lexer, exptok_queue and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "expression_tokenizer_top_defines.svh"

module expression_tokenizer_top
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    exptok_in_if.sink       in_ch,
    exptok_out_if.source    out_ch
);

    exptok_pkg::push_t          push;
    exptok_pkg::queue_status_t  q_status;

    // Scanner with its input register.
    exptok_lexer u_lexer
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .q_status (q_status),
        .push     (push)
    );

    // Result queue toward the output channel.
    exptok_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .out_ch   (out_ch),
        .q_status (q_status)
    );

    // The queue never overfills.
    `EXPTOK_ASSERT_IMP(a_no_overflow, clk, rst_n, 1'b1, q_status.count <= exptok_pkg::CNT_BITS'(exptok_pkg::QUEUE_DEPTH))
    // Input is taken only with room for two tokens left over.
    `EXPTOK_ASSERT_IMP(a_room_on_accept, clk, rst_n, in_ch.ready, q_status.count <= exptok_pkg::CNT_BITS'(exptok_pkg::QUEUE_DEPTH - 2))
    // Only the final token of a two-token step carries last.
    `EXPTOK_ASSERT_IMP(a_last_order, clk, rst_n, push.count == exptok_pkg::PUSH_TWO, !push.tok0.last && push.tok1.last)
    // Two pushed tokens are both held in the queue on the next cycle.
    `EXPTOK_ASSERT_NXT(a_two_stored, clk, rst_n, push.count == exptok_pkg::PUSH_TWO, q_status.count >= exptok_pkg::CNT_BITS'(2))

endmodule

`default_nettype wire

FILE: verif/exptok_token_checker.sv
`timescale 1ns / 1ps

// Token checker for the expression tokenizer: follows every byte transfer, predicts the
// tokens it causes and compares them, in order, with the transfers on the output channel.
// Depends on exptok_pkg and exptok_ifs.
module exptok_token_checker
    import exptok_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    exptok_in_if        in_ch,
    exptok_out_if       out_ch,
    output int unsigned failures,
    output int unsigned outstanding
);

    // Scanner modes of the predictor.
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_INT,
        SCAN_DOT,
        SCAN_FRAC,
        SCAN_IDENT,
        SCAN_HALT
    } scan_e;

    localparam int REPORT_CAP = 100;

    scan_e                    scan;
    logic [POSITION_BITS-1:0] cur_line;
    logic [POSITION_BITS-1:0] cur_col;
    logic [POSITION_BITS-1:0] lex_line;
    logic [POSITION_BITS-1:0] lex_col;
    logic [LENGTH_BITS-1:0]   lex_len;
    logic [BYTE_BITS-1:0]     lex_first;
    token_t                   step_tokens[$];
    token_t                   expected_tokens[$];

    function automatic logic numeral(input logic [BYTE_BITS-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic letter(input logic [BYTE_BITS-1:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
    endfunction

    function automatic logic blank(input logic [BYTE_BITS-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    // Returns 1 and the token kind when the byte is a one-byte operator.
    function automatic logic operator_kind(input logic [BYTE_BITS-1:0] c,
                                           output logic [KIND_BITS-1:0] kind);
        kind = KIND_PLUS;
        case (c)
            CH_PLUS:   kind = KIND_PLUS;
            CH_MINUS:  kind = KIND_MINUS;
            CH_STAR:   kind = KIND_STAR;
            CH_SLASH:  kind = KIND_SLASH;
            CH_COMMA:  kind = KIND_COMMA;
            CH_EQUAL:  kind = KIND_EQUAL;
            CH_LPAREN: kind = KIND_LPAREN;
            CH_RPAREN: kind = KIND_RPAREN;
            default:   return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void home_state();
        scan      = SCAN_IDLE;
        cur_line  = POS_ONE;
        cur_col   = POS_ONE;
        lex_line  = POS_ONE;
        lex_col   = POS_ONE;
        lex_len   = '0;
        lex_first = '0;
    endfunction

    function automatic void add_token(input logic [KIND_BITS-1:0] kind,
                                      input logic [POSITION_BITS-1:0] line,
                                      input logic [POSITION_BITS-1:0] col,
                                      input logic [LENGTH_BITS-1:0] len,
                                      input logic [BYTE_BITS-1:0] first);
        token_t t;
        t.token_kind   = kind;
        t.start_line   = line;
        t.start_column = col;
        t.token_length = len;
        t.first_byte   = first;
        t.last         = 1'b0;
        step_tokens    = {step_tokens, t};
    endfunction

    // A newline goes to column 1 of the next line; anything else moves one column on.
    function automatic void advance(input logic [BYTE_BITS-1:0] c);
        if (c == CH_LF)
        begin
            if (cur_line != POS_MAX)
                cur_line = cur_line + 1'b1;
            cur_col = POS_ONE;
        end
        else if (cur_col != POS_MAX)
        begin
            cur_col = cur_col + 1'b1;
        end
    endfunction

    function automatic void open_lexeme(input logic [BYTE_BITS-1:0] c, input scan_e mode);
        scan      = mode;
        lex_line  = cur_line;
        lex_col   = cur_col;
        lex_len   = LEN_ONE;
        lex_first = c;
        advance(c);
    endfunction

    function automatic void grow_lexeme(input logic [BYTE_BITS-1:0] c);
        if (lex_len != LEN_MAX)
            lex_len = lex_len + 1'b1;
        advance(c);
    endfunction

    function automatic void close_lexeme(input logic [KIND_BITS-1:0] kind);
        add_token(kind, lex_line, lex_col, lex_len, lex_first);
        scan = SCAN_IDLE;
    endfunction

    // A byte seen with nothing pending.
    function automatic void begin_token(input logic [BYTE_BITS-1:0] c);
        logic [KIND_BITS-1:0] kind;
        if (blank(c))
            advance(c);
        else if (operator_kind(c, kind))
        begin
            add_token(kind, cur_line, cur_col, LEN_ONE, c);
            advance(c);
        end
        else if (numeral(c))
            open_lexeme(c, SCAN_INT);
        else if (letter(c) || (c == CH_UNDER))
            open_lexeme(c, SCAN_IDENT);
        else
        begin
            add_token(KIND_INVALID, cur_line, cur_col, LEN_ONE, c);
            advance(c);
        end
    endfunction

    // Predicts the tokens of one input transfer and queues them, the final one marked last.
    function automatic void lex_step(input logic f, input logic [BYTE_BITS-1:0] c);
        token_t t;
        step_tokens.delete();
        if (f == FUNC_END)
        begin
            case (scan)
                SCAN_INT, SCAN_FRAC: close_lexeme(KIND_NUM);
                SCAN_IDENT:          close_lexeme(KIND_IDENT);
                SCAN_DOT:            close_lexeme(KIND_ERROR);
                default: ;
            endcase
            add_token(KIND_END, cur_line, cur_col, '0, '0);
            home_state();
        end
        else
        begin
            case (scan)
                SCAN_HALT: ;
                SCAN_INT:
                begin
                    if (numeral(c))
                        grow_lexeme(c);
                    else if (c == CH_DOT)
                    begin
                        grow_lexeme(c);
                        scan = SCAN_DOT;
                    end
                    else
                    begin
                        close_lexeme(KIND_NUM);
                        begin_token(c);
                    end
                end
                SCAN_DOT:
                begin
                    // A dot must be followed by a digit; otherwise report and halt.
                    if (numeral(c))
                    begin
                        grow_lexeme(c);
                        scan = SCAN_FRAC;
                    end
                    else
                    begin
                        close_lexeme(KIND_ERROR);
                        scan = SCAN_HALT;
                    end
                end
                SCAN_FRAC:
                begin
                    if (numeral(c))
                        grow_lexeme(c);
                    else
                    begin
                        close_lexeme(KIND_NUM);
                        begin_token(c);
                    end
                end
                SCAN_IDENT:
                begin
                    if (letter(c) || numeral(c) || (c == CH_UNDER))
                        grow_lexeme(c);
                    else
                    begin
                        close_lexeme(KIND_IDENT);
                        begin_token(c);
                    end
                end
                default:
                begin
                    scan = SCAN_IDLE;
                    begin_token(c);
                end
            endcase
        end
        foreach (step_tokens[i])
        begin
            t               = step_tokens[i];
            t.last          = (i == step_tokens.size() - 1);
            expected_tokens = {expected_tokens, t};
        end
    endfunction

    task automatic field_mismatch(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
        failures++;
        if (failures <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    // Compare output transfers first; a byte never yields a token in its own cycle.
    always @(posedge clk)
    begin
        token_t want;
        if (!rst_n)
        begin
            home_state();
            expected_tokens.delete();
            failures = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_CAP)
                        $display("%0t: unexpected token, expected none, actual kind %0d",
                                 $time, out_ch.token_kind);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (out_ch.token_kind !== want.token_kind)
                        field_mismatch("token_kind", 32'(want.token_kind),
                                       32'(out_ch.token_kind));
                    if (out_ch.start_line !== want.start_line)
                        field_mismatch("start_line", 32'(want.start_line),
                                       32'(out_ch.start_line));
                    if (out_ch.start_column !== want.start_column)
                        field_mismatch("start_column", 32'(want.start_column),
                                       32'(out_ch.start_column));
                    if (out_ch.token_length !== want.token_length)
                        field_mismatch("token_length", 32'(want.token_length),
                                       32'(out_ch.token_length));
                    if (out_ch.first_byte !== want.first_byte)
                        field_mismatch("first_byte", 32'(want.first_byte),
                                       32'(out_ch.first_byte));
                    if (out_ch.last !== want.last)
                        field_mismatch("last", 32'(want.last), 32'(out_ch.last));
                end
            end
            if (in_ch.valid && in_ch.ready)
                lex_step(in_ch.func, in_ch.char_code);
        end
        outstanding = expected_tokens.size();
    end

endmodule

FILE: verif/expression_tokenizer_top_tb.sv
`timescale 1ns / 1ps

// Testbench top for the expression tokenizer: clock, reset, byte stimulus and output
// back-pressure; the token checker beside the block supplies the failure count.
// Depends on exptok_pkg, exptok_ifs, exptok_token_checker and expression_tokenizer_top.
module expression_tokenizer_top_tb;
    import exptok_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CALM_ITEMS   = 150;
    localparam int MOOD_ITEMS   = 100;
    localparam int LONG_WORD    = 300;
    localparam int DRAIN_CYCLES = 16;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned failures;
    int unsigned outstanding;
    int unsigned cycles = 0;
    int unsigned sent = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;

    exptok_in_if  in_ch ();
    exptok_out_if out_ch ();

    expression_tokenizer_top uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    exptok_token_checker token_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("expression_tokenizer_top_tb: errors");
            $finish;
        end
    end

    // Token receiver: while stall_pct is set, ready drops in bursts of random length.
    initial
    begin
        int unsigned hold;
        out_ch.ready = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold != 0)
                hold--;
            else if ((stall_pct != 0) && ($urandom_range(1, 100) <= stall_pct))
            begin
                out_ch.ready <= 1'b0;
                hold = $urandom_range(0, 11);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Offers one item, maybe after an idle burst, and returns at the edge of its transfer.
    task automatic send(input logic f, input logic [BYTE_BITS-1:0] c);
        int unsigned gap;
        gap = 0;
        if ((gap_pct != 0) && ($urandom_range(1, 100) <= gap_pct))
            gap = $urandom_range(1, 12);
        @(negedge clk);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.func      <= f;
        in_ch.char_code <= c;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        sent++;
    endtask

    task automatic feed_byte(input logic [BYTE_BITS-1:0] c);
        send(FUNC_BYTE, c);
    endtask

    // The byte field is don't-care at end of input, so it gets noise.
    task automatic feed_end();
        send(FUNC_END, BYTE_BITS'($urandom_range(0, 255)));
    endtask

    task automatic feed_text(input string s);
        foreach (s[i])
            feed_byte(s[i]);
    endtask

    // Sender goes quiet until every predicted token has been delivered.
    task automatic hold_until_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    function automatic logic [BYTE_BITS-1:0] any_digit();
        return CH_ZERO + BYTE_BITS'($urandom_range(0, 9));
    endfunction

    function automatic logic [BYTE_BITS-1:0] any_letter();
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + BYTE_BITS'($urandom_range(0, 25));
    endfunction

    function automatic logic [BYTE_BITS-1:0] any_word_char();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return any_letter();
        else if (pick < 9)
            return any_digit();
        return CH_UNDER;
    endfunction

    function automatic logic [BYTE_BITS-1:0] any_operator();
        logic [BYTE_BITS-1:0] ops [8] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                          CH_COMMA, CH_EQUAL, CH_LPAREN, CH_RPAREN};
        return ops[$urandom_range(0, 7)];
    endfunction

    function automatic logic [BYTE_BITS-1:0] any_blank();
        logic [BYTE_BITS-1:0] blanks [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
        return blanks[$urandom_range(0, 3)];
    endfunction

    // One random piece of source text: mostly well-formed tokens, some noise and breakage.
    task automatic feed_piece();
        int unsigned          pick;
        logic [BYTE_BITS-1:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            repeat ($urandom_range(1, 4)) feed_byte(any_digit());
            if ($urandom_range(0, 2) == 0)
            begin
                feed_byte(CH_DOT);
                repeat ($urandom_range(1, 3)) feed_byte(any_digit());
            end
        end
        else if (pick < 55)
        begin
            feed_byte(($urandom_range(0, 7) == 0) ? CH_UNDER : any_letter());
            repeat ($urandom_range(0, 6)) feed_byte(any_word_char());
        end
        else if (pick < 75)
            feed_byte(any_operator());
        else if (pick < 87)
            feed_byte(any_blank());
        else if (pick < 92)
            feed_byte(BYTE_BITS'($urandom_range(0, 255)));
        else if (pick < 95)
        begin
            // Number whose dot is not followed by a digit, then one to three halted bytes and the end of input.
            repeat ($urandom_range(1, 3)) feed_byte(any_digit());
            feed_byte(CH_DOT);
            do
                c = BYTE_BITS'($urandom_range(0, 255));
            while ((c >= CH_ZERO) && (c <= CH_NINE));
            feed_byte(c);
            repeat ($urandom_range(0, 2)) feed_byte(BYTE_BITS'($urandom_range(0, 255)));
            feed_end();
        end
        else if (pick < 97)
        begin
            // Second dot after the fraction.
            feed_byte(any_digit());
            feed_byte(CH_DOT);
            repeat ($urandom_range(1, 2)) feed_byte(any_digit());
            feed_byte(CH_DOT);
        end
        else
            feed_end();
    endtask

    initial
    begin
        int unsigned start;
        int unsigned next_mood;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.func      = FUNC_BYTE;
        in_ch.char_code = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every operator, a second dot, zero and high bytes, blanks,
        // a dot without digit with a halted byte, and every kind of pending token at the end.
        feed_text("ab_9+1.5.-*/,=()");
        feed_byte(8'h00);
        feed_byte(8'hFF);
        feed_text("\t\r\n3.x");
        feed_byte(CH_LA);
        feed_end();
        feed_text("7.");
        feed_end();
        feed_text("_z");
        feed_end();
        feed_text("42");
        feed_end();
        hold_until_drained();

        // Saturation: token length pinned at its maximum.
        stall_pct = 20;
        feed_byte(CH_LA);
        repeat (LONG_WORD) feed_byte(any_word_char());
        feed_byte(CH_PLUS);
        feed_text("9+");
        feed_end();
        hold_until_drained();

        // Random text, with the idling mood changing every so often and none at the end.
        start     = sent;
        next_mood = sent;
        while (sent - start < RANDOM_ITEMS)
        begin
            if (sent - start >= RANDOM_ITEMS - CALM_ITEMS)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else if (sent >= next_mood)
            begin
                gap_pct   = 10 * $urandom_range(0, 3);
                stall_pct = 10 * $urandom_range(0, 3);
                next_mood = sent + MOOD_ITEMS;
                if ($urandom_range(0, 2) == 0)
                    hold_until_drained();
            end
            feed_piece();
        end
        feed_end();

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (failures == 0)
            $display("expression_tokenizer_top_tb: clean");
        else
            $display("expression_tokenizer_top_tb: errors");
        $finish;
    end

endmodule
